// ===== hw/rtl/tsdc_pkg.sv =====
// ----------------------------------------------------------------------------
// tsdc_pkg: shared types and constants for the draw command generator
// Holds the register indexes, the field constants of tiles and sprites and
// the structs passed between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package tsdc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_BANK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLIP_SCREEN  = 2'd2;
  localparam int CFG_DATA_W = 8;

  // Defaults of the top level parameters
  localparam int SCREEN_WIDTH_DEF  = 256;
  localparam int SCREEN_HEIGHT_DEF = 192;
  localparam int QUEUE_DEPTH_DEF   = 4;

  // Item kinds and draw sizes
  localparam logic MODE_TILE   = 1'b0;
  localparam logic MODE_SPRITE = 1'b1;
  localparam logic SIZE_TILE   = 1'b0;
  localparam logic SIZE_SPRITE = 1'b1;

  // Tile colour groups and row/column limits
  localparam logic [4:0] COLOR_BAND_TOP = 5'h15;
  localparam logic [4:0] COLOR_BAND_MID = 5'h16;
  localparam logic [4:0] COLOR_BAND_BOT = 5'h14;
  localparam logic [3:0] COLOR_ROW_SEL  = 4'hc;
  localparam logic [4:0] COL_BAND_START = 5'h1e;
  localparam logic [4:0] ROW_BAND_MID   = 5'h0c;
  localparam logic [4:0] ROW_BAND_BOT   = 5'h14;
  localparam logic [4:0] ROW_SPECIAL_A  = 5'h04;
  localparam logic [4:0] ROW_SPECIAL_B  = 5'h1b;
  localparam logic [4:0] WIN_COL_LO     = 5'd8;
  localparam logic [4:0] WIN_COL_HI     = 5'd12;
  localparam logic [4:0] WIN_ROW_LO     = 5'd6;
  localparam logic [4:0] WIN_ROW_HI     = 5'd26;
  localparam logic [4:0] WIN_ROW_LO_FL  = 5'd5;
  localparam logic [4:0] WIN_ROW_HI_FL  = 5'd25;
  localparam logic [8:0] Y_OFFSET       = 9'd32;

  // Sprite constants
  localparam logic [7:0] SPR_PAIR_CODE  = 8'h20;
  localparam logic [7:0] SPR_SECOND_BIT = 8'h01;
  localparam logic [8:0] SPR_STEP       = 9'h10;
  localparam logic [7:0] SPR_Y_RAW_MIN  = 8'd25;
  localparam int         SPR_Y_BIAS     = 32;

  typedef struct packed {
    logic       palette_bank;
    logic [2:0] scroll_rows;
    logic       flip_screen;
  } cfg_t;

  // One queued job: the first draw plus how to derive a second one
  typedef struct packed {
    logic       size;
    logic [7:0] code;
    logic [8:0] x;
    logic [8:0] y;
    logic [4:0] color;
    logic       pair;
    logic       across;
  } job_t;

endpackage

// ===== hw/rtl/tsdc_front.sv =====
// ----------------------------------------------------------------------------
// tsdc_front: item classifier
// Decodes a tile cell or a sprite attribute set into one queued job, or
// drops it when the sprite is disabled or clipped.
// ----------------------------------------------------------------------------
module tsdc_front #(
  parameter int SCREEN_WIDTH  = 256,
  parameter int SCREEN_HEIGHT = 192
) (
  input  logic           accept,
  input  tsdc_pkg::cfg_t cfg,
  input  logic           in_mode,
  input  logic [9:0]     in_cell_index,
  input  logic [7:0]     in_cell_code,
  input  logic [7:0]     in_sprite_byte0,
  input  logic [7:0]     in_sprite_byte1,
  input  logic [7:0]     in_sprite_byte2,
  input  logic [7:0]     in_sprite_byte3,
  output logic           push,
  output tsdc_pkg::job_t job
);
  import tsdc_pkg::*;

  localparam logic [10:0] X_LIM = 11'(SCREEN_WIDTH);
  localparam logic [10:0] Y_LIM = 11'(SCREEN_HEIGHT + SPR_Y_BIAS);

  logic [4:0] col, row, fcol, frow;
  logic       win;
  logic [4:0] tcolor;
  logic [8:0] ty;
  logic [8:0] sx;
  logic [7:0] sbase;
  logic       clip;
  logic       keep;

  assign col  = in_cell_index[4:0];
  assign row  = in_cell_index[9:5];
  // mirror: 31 - v on five bits
  assign fcol = cfg.flip_screen ? ~col : col;
  assign frow = cfg.flip_screen ? ~row : row;

  always_comb begin
    if (cfg.flip_screen) begin
      win = (row >= WIN_ROW_LO_FL) && (row <= WIN_ROW_HI_FL) &&
            (col >= WIN_COL_LO) && (col <= WIN_COL_HI);
    end else begin
      win = (row >= WIN_ROW_LO) && (row <= WIN_ROW_HI) &&
            (col >= WIN_COL_LO) && (col <= WIN_COL_HI);
    end
  end

  always_comb begin
    if (fcol >= COL_BAND_START) begin
      if (frow < ROW_BAND_MID) begin
        tcolor = COLOR_BAND_TOP;
      end else if (frow < ROW_BAND_BOT) begin
        tcolor = COLOR_BAND_MID;
      end else begin
        tcolor = COLOR_BAND_BOT;
      end
    end else if (frow == ROW_SPECIAL_A || frow == ROW_SPECIAL_B) begin
      tcolor = {cfg.palette_bank, COLOR_ROW_SEL};
    end else begin
      tcolor = {cfg.palette_bank, fcol[4:1]};
    end
  end

  assign ty = {1'b0, frow, 3'b000} - {6'd0, (win ? cfg.scroll_rows : 3'd0)} - Y_OFFSET;

  assign sx    = 9'd256 - {1'b0, in_sprite_byte2};
  assign sbase = {3'd0, ~in_sprite_byte0[3:0], 1'b0};
  assign clip  = (in_sprite_byte1 < SPR_Y_RAW_MIN) ||
                 ({2'd0, sx} >= X_LIM) ||
                 ({3'd0, in_sprite_byte1} >= Y_LIM);

  always_comb begin
    job  = '0;
    keep = 1'b0;
    case (in_mode)
      MODE_TILE: begin
        keep      = 1'b1;
        job.size  = SIZE_TILE;
        job.code  = in_cell_code;
        job.x     = {1'b0, fcol, 3'b000};
        job.y     = ty;
        job.color = tcolor;
      end
      default: begin
        keep       = in_sprite_byte3[3] && !clip;
        job.size   = SIZE_SPRITE;
        job.x      = sx;
        job.y      = {1'b0, in_sprite_byte1} - Y_OFFSET;
        job.color  = {2'd0, ~in_sprite_byte3[2:0]};
        job.pair   = !in_sprite_byte0[7];
        job.across = in_sprite_byte0[1];
        if (in_sprite_byte0[7]) begin
          // single sprite: odd code unless flipped
          job.code = sbase | {7'd0, !cfg.flip_screen};
        end else begin
          job.code = sbase | SPR_PAIR_CODE;
        end
      end
    endcase
  end

  assign push = accept && keep;

endmodule

// ===== hw/rtl/tsdc_queue.sv =====
// ----------------------------------------------------------------------------
// tsdc_queue: job queue
// Small register FIFO between the classifier and the command emitter.
// ----------------------------------------------------------------------------
module tsdc_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  tsdc_pkg::job_t push_job,
  input  logic           pop,
  output tsdc_pkg::job_t head_job,
  output logic           empty,
  output logic           full
);
  import tsdc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_FULL);
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== hw/rtl/tsdc_back.sv =====
// ----------------------------------------------------------------------------
// tsdc_back: command emitter
// Emits one draw command per cycle from the queue head while a job waits; a
// sprite pair yields two, the second offset across or down by sixteen pixels.
// ----------------------------------------------------------------------------
module tsdc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  tsdc_pkg::job_t head_job,
  input  logic           empty,
  output logic           pop,
  output logic           out_valid,
  output logic           out_draw_size,
  output logic [7:0]     out_draw_code,
  output logic [8:0]     out_draw_x,
  output logic signed [8:0] out_draw_y,
  output logic [4:0]     out_draw_color,
  output logic           out_last
);
  import tsdc_pkg::*;

  logic       second_r, second_nxt;
  logic       valid_r;
  logic       size_r;
  logic [7:0] code_r;
  logic [8:0] x_r;
  logic [8:0] y_r;
  logic [4:0] color_r;
  logic       last_r;

  logic       last_nxt;
  logic [7:0] code_nxt;
  logic [8:0] x_nxt, y_nxt;

  always_comb begin
    last_nxt   = !head_job.pair || second_r;
    code_nxt   = head_job.code;
    x_nxt      = head_job.x;
    y_nxt      = head_job.y;
    if (second_r) begin
      code_nxt = head_job.code | SPR_SECOND_BIT;
      if (head_job.across) begin
        x_nxt = head_job.x + SPR_STEP;
      end else begin
        y_nxt = head_job.y + SPR_STEP;
      end
    end
    pop        = !empty && last_nxt;
    second_nxt = second_r;
    if (!empty) begin
      second_nxt = !last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r <= 1'b0;
      valid_r  <= 1'b0;
    end else begin
      second_r <= second_nxt;
      valid_r  <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    size_r  <= head_job.size;
    code_r  <= code_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    color_r <= head_job.color;
    last_r  <= last_nxt;
  end

  assign out_valid      = valid_r;
  assign out_draw_size  = size_r;
  assign out_draw_code  = code_r;
  assign out_draw_x     = x_r;
  assign out_draw_y     = y_r;
  assign out_draw_color = color_r;
  assign out_last       = last_r;

endmodule

// ===== hw/rtl/tile_sprite_draw_command_generator_core.sv =====
// ----------------------------------------------------------------------------
// tile_sprite_draw_command_generator_core: tile and sprite draw commands
// Turns video memory entries into 8x8 tile and 16x16 sprite draw commands.
// ----------------------------------------------------------------------------
// An item is taken on any clock edge where start is high and busy is low;
// it passes through the job queue and the emitter's output registers, and
// its draw commands leave on the out_ ports one per cycle, each marked by a
// single-cycle out_valid pulse; the receiver cannot stall, so every pulse is
// a completed transfer. Tile cells and single sprites yield one command,
// sprite pairs two, and disabled or clipped sprites none. The emitter is the
// limit: it drains one command per cycle from a QUEUE_DEPTH-entry job queue,
// and busy rises only while that queue is full, so a steady stream of tiles
// and single sprites runs at one item per cycle while a run of pairs fills
// the queue and is then paced by busy. out_last marks the final command of
// each item. Configuration writes are always ready (cfg_ready tied high);
// write them only while no commands are pending.
// ----------------------------------------------------------------------------
module tile_sprite_draw_command_generator_core #(
  parameter int SCREEN_WIDTH  = tsdc_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = tsdc_pkg::SCREEN_HEIGHT_DEF,
  parameter int QUEUE_DEPTH   = tsdc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command input
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic [9:0]                    in_cell_index,
  input  logic [7:0]                    in_cell_code,
  input  logic [7:0]                    in_sprite_byte0,
  input  logic [7:0]                    in_sprite_byte1,
  input  logic [7:0]                    in_sprite_byte2,
  input  logic [7:0]                    in_sprite_byte3,
  // draw command output
  output logic                          out_valid,
  output logic                          out_draw_size,
  output logic [7:0]                    out_draw_code,
  output logic [8:0]                    out_draw_x,
  output logic signed [8:0]             out_draw_y,
  output logic [4:0]                    out_draw_color,
  output logic                          out_last,
  // configuration writes
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tsdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsdc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tsdc_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic accept;
  logic push, pop, empty, full;
  job_t push_job, head_job;

  // Configuration registers: always ready, one register per transfer
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PALETTE_BANK: cfg_nxt.palette_bank = cfg_data[0];
        CFG_SCROLL_ROWS:  cfg_nxt.scroll_rows  = cfg_data[2:0];
        CFG_FLIP_SCREEN:  cfg_nxt.flip_screen  = cfg_data[0];
        default:          cfg_nxt = cfg_r;  // unused index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Hold off new items only while the job queue has no free slot
  assign busy   = full;
  assign accept = start && !busy;

  // Front end: classify the item and compute its first draw
  tsdc_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .accept          (accept),
    .cfg             (cfg_r),
    .in_mode         (in_mode),
    .in_cell_index   (in_cell_index),
    .in_cell_code    (in_cell_code),
    .in_sprite_byte0 (in_sprite_byte0),
    .in_sprite_byte1 (in_sprite_byte1),
    .in_sprite_byte2 (in_sprite_byte2),
    .in_sprite_byte3 (in_sprite_byte3),
    .push            (push),
    .job             (push_job)
  );

  // Job queue decouples the classifier from the emitter
  tsdc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (empty),
    .full     (full)
  );

  // Back end: emit one registered draw command per cycle while jobs wait
  tsdc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_job       (head_job),
    .empty          (empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_draw_size  (out_draw_size),
    .out_draw_code  (out_draw_code),
    .out_draw_x     (out_draw_x),
    .out_draw_y     (out_draw_y),
    .out_draw_color (out_draw_color),
    .out_last       (out_last)
  );

endmodule

// ===== tb/sv/tile_sprite_draw_command_generator_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Draw command generator testbench
// Sends tile cells and sprite attribute entries through the command port
// under several register settings and checks every draw command against an
// in-bench prediction of the expected draws.
// ----------------------------------------------------------------------------
module tile_sprite_draw_command_generator_core_tb;
  import tsdc_pkg::*;

  localparam int SCREEN_W       = SCREEN_WIDTH_DEF;
  localparam int SCREEN_H       = SCREEN_HEIGHT_DEF;
  localparam int SETTLE_CYCLES  = 16;   // pipeline plus job queue, with margin
  localparam int END_WAIT       = 2000;
  localparam int WATCHDOG_LIMIT = 400;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 116;

  // One video memory entry as offered on the command port
  typedef struct {
    logic       mode;
    logic [9:0] cell_index;
    logic [7:0] cell_code;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
  } vram_entry_t;

  // One draw command as it should appear on the out_ ports
  typedef struct {
    logic       size;
    logic [7:0] code;
    logic [8:0] x;
    logic [8:0] y;
    logic [4:0] color;
    logic       last;
  } draw_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_mode = 1'b0;
  logic [9:0]            in_cell_index = '0;
  logic [7:0]            in_cell_code = '0;
  logic [7:0]            in_sprite_byte0 = '0;
  logic [7:0]            in_sprite_byte1 = '0;
  logic [7:0]            in_sprite_byte2 = '0;
  logic [7:0]            in_sprite_byte3 = '0;
  logic                  out_valid;
  logic                  out_draw_size;
  logic [7:0]            out_draw_code;
  logic [8:0]            out_draw_x;
  logic signed [8:0]     out_draw_y;
  logic [4:0]            out_draw_color;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Bench copy of the register file
  logic       pal_bank = 1'b0;
  logic [2:0] scroll = 3'd0;
  logic       flipped = 1'b0;

  vram_entry_t entries_todo[$];
  draw_cmd_t   draws_due[$];
  vram_entry_t offered;

  int gap_left = 0;
  int gap_pct = 0;
  bit no_gaps = 1'b0;
  int dead_cycles = 0;
  int mismatches = 0;
  int items_taken = 0;
  int tiles_seen = 0;
  int sprites_seen = 0;
  int draws_checked = 0;
  int settings_run = 0;

  tile_sprite_draw_command_generator_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_cell_index   (in_cell_index),
    .in_cell_code    (in_cell_code),
    .in_sprite_byte0 (in_sprite_byte0),
    .in_sprite_byte1 (in_sprite_byte1),
    .in_sprite_byte2 (in_sprite_byte2),
    .in_sprite_byte3 (in_sprite_byte3),
    .out_valid       (out_valid),
    .out_draw_size   (out_draw_size),
    .out_draw_code   (out_draw_code),
    .out_draw_x      (out_draw_x),
    .out_draw_y      (out_draw_y),
    .out_draw_color  (out_draw_color),
    .out_last        (out_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Draw prediction: expand one accepted entry into the draws it must cause,
  // using the register values in force when it was taken.
  // --------------------------------------------------------------------------
  function automatic void plan_draws(input vram_entry_t e);
    logic [4:0] col;
    logic [4:0] row;
    logic       in_window;
    logic [4:0] color;
    logic [7:0] base;
    int         x;
    int         y;
    draw_cmd_t  d;
    if (e.mode == MODE_TILE) begin
      tiles_seen++;
      col = e.cell_index[4:0];
      row = e.cell_index[9:5];
      // The scroll window is judged on the source cell, before mirroring,
      // and sits one row higher when the screen is flipped.
      if (flipped) begin
        in_window = row >= 5'd5 && row <= 5'd25 && col >= 5'd8 && col <= 5'd12;
        col = ~col;
        row = ~row;
      end else begin
        in_window = row >= 5'd6 && row <= 5'd26 && col >= 5'd8 && col <= 5'd12;
      end
      // Right-hand column bands win over the special rows, which win over
      // the plain column-pair groups.
      if (col >= 5'd30) begin
        if (row < 5'd12)      color = 5'h15;
        else if (row < 5'd20) color = 5'h16;
        else                  color = 5'h14;
      end else if (row == 5'd4 || row == 5'd27) begin
        color = {pal_bank, 4'hc};
      end else begin
        color = {pal_bank, col[4:1]};
      end
      x = col;
      x = x * 8;
      y = row;
      y = y * 8 - 32;
      if (in_window) y = y - int'(scroll);
      d = '{SIZE_TILE, e.cell_code, x[8:0], y[8:0], color, 1'b1};
      draws_due.push_back(d);
    end else begin
      sprites_seen++;
      if (!e.b3[3]) return;  // disabled: nothing drawn
      x = e.b2;
      x = 256 - x;
      y = e.b1;
      y = y - 32;
      // Clip on the first part only; the second half of a pair follows.
      if (x < 0 || y < -7 || x >= SCREEN_W || y >= SCREEN_H) return;
      base = {3'b000, ~e.b0[3:0], 1'b0};
      color = {2'b00, ~e.b3[2:0]};
      if (e.b0[7]) begin
        if (!flipped) base = base + 8'd1;
        d = '{SIZE_SPRITE, base, x[8:0], y[8:0], color, 1'b1};
        draws_due.push_back(d);
      end else begin
        d = '{SIZE_SPRITE, base | 8'h20, x[8:0], y[8:0], color, 1'b0};
        draws_due.push_back(d);
        if (e.b0[1]) x = x + 16;
        else         y = y + 16;
        d = '{SIZE_SPRITE, base | 8'h21, x[8:0], y[8:0], color, 1'b1};
        draws_due.push_back(d);
      end
    end
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t mismatch on %s: got %0d, want %0d (draw %0d)",
             $realtime, what, got, want, draws_checked);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offer queued entries on the command port. Hold the current
  // entry while busy is high; once it transfers either present the next
  // one at once or drop start for a short random gap.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        plan_draws(offered);
        items_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (entries_todo.size() == 0) begin
          start <= 1'b0;
        end else if (!no_gaps && $urandom_range(99) < gap_pct) begin
          gap_left <= $urandom_range(4);
          start <= 1'b0;
        end else begin
          offered = entries_todo.pop_front();
          in_mode <= offered.mode;
          in_cell_index <= offered.cell_index;
          in_cell_code <= offered.cell_code;
          in_sprite_byte0 <= offered.b0;
          in_sprite_byte1 <= offered.b1;
          in_sprite_byte2 <= offered.b2;
          in_sprite_byte3 <= offered.b3;
          start <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: every out_valid pulse is a transfer; match it field by field
  // against the oldest expected draw.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    draw_cmd_t want;
    if (rst_n && out_valid) begin
      draws_checked++;
      if (draws_due.size() == 0) begin
        flag_mismatch("draw with none expected, code", out_draw_code, 0);
      end else begin
        want = draws_due.pop_front();
        if (out_draw_size !== want.size)
          flag_mismatch("draw_size", out_draw_size, want.size);
        if (out_draw_code !== want.code)
          flag_mismatch("draw_code", out_draw_code, want.code);
        if (out_draw_x !== want.x)
          flag_mismatch("draw_x", out_draw_x, want.x);
        if (out_draw_y !== want.y)
          flag_mismatch("draw_y", out_draw_y, $signed(want.y));
        if (out_draw_color !== want.color)
          flag_mismatch("draw_color", out_draw_color, want.color);
        if (out_last !== want.last)
          flag_mismatch("last", out_last, want.last);
      end
    end
  end

  // Watchdog: end the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      dead_cycles <= 0;
    end else if (dead_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", dead_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  function automatic void add_tile(input int idx, input int code);
    vram_entry_t e;
    e = '{MODE_TILE, 10'(idx), 8'(code), 8'($urandom), 8'($urandom),
          8'($urandom), 8'($urandom)};
    entries_todo.push_back(e);
  endfunction

  function automatic void add_sprite(input int b0, input int b1, input int b2,
                                     input int b3);
    vram_entry_t e;
    e = '{MODE_SPRITE, 10'($urandom), 8'($urandom), 8'(b0), 8'(b1), 8'(b2), 8'(b3)};
    entries_todo.push_back(e);
  endfunction

  // Half tile cells; the rest mostly on-screen enabled sprites, with some raw
  // noise that exercises the disable and clip paths.
  function automatic void add_random_entry();
    if ($urandom_range(1) == 0) begin
      add_tile($urandom_range(1023), $urandom_range(255));
    end else if ($urandom_range(99) < 85) begin
      add_sprite($urandom_range(255), $urandom_range(223, 25), $urandom_range(255, 1),
                 $urandom_range(255) | 8'h08);
    end else begin
      add_sprite($urandom_range(255), $urandom_range(255), $urandom_range(255),
                 $urandom_range(255));
    end
  endfunction

  // Wait until all entries have transferred and all draws arrived, then let
  // entries that draw nothing clear the pipeline.
  task automatic settle_idle();
    while (entries_todo.size() != 0 || start || draws_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register; fill the unused upper data bits with noise.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    logic [CFG_DATA_W-1:0] keep;
    keep = (idx == CFG_SCROLL_ROWS) ? 8'h07 : 8'h01;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= (8'($urandom) & ~keep) | (8'(value) & keep);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PALETTE_BANK: pal_bank = value[0];
      CFG_SCROLL_ROWS:  scroll = value[2:0];
      CFG_FLIP_SCREEN:  flipped = value[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_setting(input int bank, input int rows, input int flip);
    write_reg(CFG_PALETTE_BANK, bank);
    write_reg(CFG_SCROLL_ROWS, rows);
    write_reg(CFG_FLIP_SCREEN, flip);
    settings_run++;
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset, directed entries at the reset setting and at the top
  // setting, then random phases over varied settings; the last phase runs
  // with no gaps at all.
  // --------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    settings_run = 1;

    // Reset setting: corners, colour bands, special rows, window edges and
    // every sprite outcome, including each clip boundary.
    gap_pct = 30;
    add_tile(0, 8'h00);
    add_tile(1023, 8'hff);
    add_tile(31, 8'h5a);
    add_tile(12 * 32 + 30, 8'h11);
    add_tile(19 * 32 + 31, 8'h22);
    add_tile(20 * 32 + 30, 8'h33);
    add_tile(4 * 32 + 3, 8'h44);
    add_tile(27 * 32 + 5, 8'h55);
    add_tile(6 * 32 + 8, 8'h66);
    add_tile(26 * 32 + 12, 8'h77);
    add_sprite(8'h00, 8'h80, 8'h80, 8'hf7);   // disabled
    add_sprite(8'h80, 8'd25, 8'd255, 8'h08);  // single at top edge
    add_sprite(8'h02, 8'd223, 8'd1, 8'h0f);   // pair across at far corner
    add_sprite(8'h00, 8'h80, 8'h80, 8'hff);   // pair stacked down
    add_sprite(8'h80, 8'd24, 8'h80, 8'h08);   // clipped above
    add_sprite(8'h80, 8'd224, 8'h80, 8'h08);  // clipped below
    add_sprite(8'h80, 8'h80, 8'd0, 8'h08);    // clipped right
    settle_idle();

    // Top setting: flipped window edges, a mirrored corner, a flipped single and pair.
    apply_setting(1, 7, 1);
    add_tile(5 * 32 + 8, 8'h81);
    add_tile(25 * 32 + 12, 8'h82);
    add_tile(26 * 32 + 8, 8'h83);
    add_tile(6 * 32 + 7, 8'h84);
    add_tile(0, 8'hff);
    add_sprite(8'hff, 8'd100, 8'd128, 8'h08);
    add_sprite(8'h7f, 8'd100, 8'd128, 8'h08);
    settle_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       apply_setting(1, 7, 1);
        1:       apply_setting(0, 0, 0);
        default: apply_setting($urandom_range(1), $urandom_range(7), $urandom_range(1));
      endcase
      case ($urandom_range(2))
        0:       gap_pct = 0;
        1:       gap_pct = 20;
        default: gap_pct = 50;
      endcase
      no_gaps = (p == RANDOM_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) add_random_entry();
      if (p != RANDOM_PHASES - 1) settle_idle();
    end

    // Drain: wait a bounded time for the remaining draws, then let the
    // pipeline go quiet before judging leftovers.
    for (int i = 0; i < END_WAIT; i++) begin
      if (entries_todo.size() == 0 && !start && draws_due.size() == 0) break;
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (draws_due.size() != 0)
      flag_mismatch("draws never produced, count", 0, draws_due.size());

    $display("covered %0d entries (%0d tile cells, %0d sprites) over %0d settings",
             items_taken, tiles_seen, sprites_seen, settings_run);
    $display("checked %0d draw commands, %0d mismatches", draws_checked, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tsdc_pkg.sv
hw/rtl/tsdc_front.sv
hw/rtl/tsdc_queue.sv
hw/rtl/tsdc_back.sv
hw/rtl/tile_sprite_draw_command_generator_core.sv
tb/sv/tile_sprite_draw_command_generator_core_tb.sv
